FILE: design/triangle_rasterizer_zbuffer_assert.svh
// Assertion macros for the triangle rasterizer checker
`ifndef TRIANGLE_RASTERIZER_ZBUFFER_ASSERT_SVH
`define TRIANGLE_RASTERIZER_ZBUFFER_ASSERT_SVH

// same-cycle implication
`define TRZ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TRZ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/trz_pkg.sv
// Shared constants, types and codes for the triangle rasterizer
package trz_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * 4;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int XW          = $clog2(MAX_WIDTH);
  localparam int YW          = $clog2(MAX_HEIGHT);

  localparam int CW   = 24;        // coordinate and depth width
  localparam int VW   = CW + 1;    // vertex differences
  localparam int PW   = CW + 2;    // sample minus vertex
  localparam int MAW  = 34;        // multiplier operand a
  localparam int MBW  = 26;        // multiplier operand b
  localparam int PRW  = MAW + MBW; // product
  localparam int EW   = 54;        // edge functions and area
  localparam int QW   = 32;        // barycentric weight fraction bits
  localparam int RAMW = CW + 8;    // depth and coverage code

  localparam logic [7:0] MAX_W_CELLS = 8'(MAX_WIDTH);
  localparam logic [6:0] MAX_H_CELLS = 7'(MAX_HEIGHT);

  localparam logic signed [CW-1:0] DEPTH_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] DEPTH_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] NEAR_LIMIT = -CW'(3277);

  localparam logic [7:0] CODE_MODE0 = 8'd32;
  localparam logic [7:0] CODE_MODE1 = 8'd1;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_TRI   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] STS_DONE  = 2'd0;
  localparam logic [1:0] STS_NEAR  = 2'd1;
  localparam logic [1:0] STS_DEGEN = 2'd2;

  localparam logic [1:0] REG_SAMPLE_MODE   = 2'd0;
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

  typedef enum logic [4:0] {
    S_RST_CLEAR, S_IDLE, S_CLEAR, S_TRI_DIFF, S_TRI_AREA, S_TRI_D, S_TRI_CHECK,
    S_PT, S_S_MUL, S_T_MUL, S_EDGE, S_INSIDE, S_DIV, S_Z_MUL, S_Z_SUM,
    S_SAMP_RD, S_DTEST, S_NEXT, S_READ_ADDR, S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic tri_diff;
    logic tri_area;
    logic tri_d;
    logic tri_init;
    logic pt;
    logic s_mul;
    logic t_mul;
    logic edg;
    logic div_init;
    logic div_step;
    logic z_mul;
    logic z_sum;
    logic dtest;
    logic next;
    logic read_issue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic near;
    logic degen;
    logic box_empty;
    logic in_tri;
    logic div_last;
    logic last_sample;
  } stat_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] eff_w;
    logic [6:0] eff_h;
  } cfg_t;

endpackage

FILE: design/trz_ram.sv
// Generic single-write, single-read RAM with registered read data
module trz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/trz_ctrl.sv
// Sequencing state machine for the triangle rasterizer
module trz_ctrl import trz_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] op,
  input  stat_t      st,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_RST_CLEAR: if (st.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_CLEAR: state_nxt = S_CLEAR;
            OP_TRI:   state_nxt = S_TRI_DIFF;
            OP_READ:  state_nxt = S_READ_ADDR;
            default:  state_nxt = S_FINISH;
          endcase
        end
      end
      S_CLEAR:     if (st.clr_last) state_nxt = S_FINISH;
      S_TRI_DIFF:  state_nxt = S_TRI_AREA;
      S_TRI_AREA:  state_nxt = S_TRI_D;
      S_TRI_D:     state_nxt = S_TRI_CHECK;
      S_TRI_CHECK: begin
        if (st.near || st.degen || st.box_empty) state_nxt = S_FINISH;
        else state_nxt = S_PT;
      end
      S_PT:        state_nxt = S_S_MUL;
      S_S_MUL:     state_nxt = S_T_MUL;
      S_T_MUL:     state_nxt = S_EDGE;
      S_EDGE:      state_nxt = S_INSIDE;
      S_INSIDE:    state_nxt = st.in_tri ? S_DIV : S_NEXT;
      S_DIV:       if (st.div_last) state_nxt = S_Z_MUL;
      S_Z_MUL:     state_nxt = S_Z_SUM;
      S_Z_SUM:     state_nxt = S_SAMP_RD;
      S_SAMP_RD:   state_nxt = S_DTEST;
      S_DTEST:     state_nxt = S_NEXT;
      S_NEXT:      state_nxt = st.last_sample ? S_FINISH : S_PT;
      S_READ_ADDR: state_nxt = S_FINISH;
      S_FINISH:    state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_RST_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE:      cmd.load = start;
      S_CLEAR:     cmd.clr_step = 1'b1;
      S_TRI_DIFF:  cmd.tri_diff = 1'b1;
      S_TRI_AREA:  cmd.tri_area = 1'b1;
      S_TRI_D:     cmd.tri_d = 1'b1;
      S_TRI_CHECK: cmd.tri_init = 1'b1;
      S_PT:        cmd.pt = 1'b1;
      S_S_MUL:     cmd.s_mul = 1'b1;
      S_T_MUL:     cmd.t_mul = 1'b1;
      S_EDGE:      cmd.edg = 1'b1;
      S_INSIDE:    cmd.div_init = st.in_tri;
      S_DIV:       cmd.div_step = 1'b1;
      S_Z_MUL:     cmd.z_mul = 1'b1;
      S_Z_SUM:     cmd.z_sum = 1'b1;
      S_SAMP_RD:   cmd = '0;
      S_DTEST:     cmd.dtest = 1'b1;
      S_NEXT:      cmd.next = !st.last_sample;
      S_READ_ADDR: cmd.read_issue = 1'b1;
      S_FINISH:    cmd.emit = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule

FILE: design/trz_dp.sv
// Datapath: setup, edge functions, weight divider, depth interpolation, depth store
module trz_dp import trz_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  cfg_t                 cfg,
  output stat_t                st,
  input  logic [1:0]           in_operation,
  input  logic signed [CW-1:0] in_vertex_a_x,
  input  logic signed [CW-1:0] in_vertex_a_y,
  input  logic signed [CW-1:0] in_vertex_b_x,
  input  logic signed [CW-1:0] in_vertex_b_y,
  input  logic signed [CW-1:0] in_vertex_c_x,
  input  logic signed [CW-1:0] in_vertex_c_y,
  input  logic signed [CW-1:0] in_depth_a,
  input  logic signed [CW-1:0] in_depth_b,
  input  logic signed [CW-1:0] in_depth_c,
  input  logic [7:0]           in_read_x,
  input  logic [6:0]           in_read_y,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [15:0]          out_samples_written,
  output logic [7:0]           out_sample_code,
  output logic signed [CW-1:0] out_sample_depth
);

  logic [1:0]           op_r;
  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r, za_r, zb_r, zc_r;
  logic [7:0]           rx_r;
  logic [6:0]           ry_r;

  logic signed [VW-1:0] v0x_r, v0y_r, v1x_r, v1y_r, dzb_r, dzc_r;
  logic signed [CW-1:0] minx_r, maxx_r, miny_r, maxy_r;
  logic                 near_r, degen_r, neg_r, box_empty_r;
  logic signed [EW-1:0] dd_r;
  logic [XW-1:0]        sx_r, ex_r, x_r;
  logic [YW-1:0]        sy_r, ey_r, y_r;
  logic                 dx_r, dy_r;
  logic signed [PW-1:0] v2x_r, v2y_r;
  logic signed [PRW-1:0] p0_r, p1_r;
  logic signed [EW-1:0] s_r, t_r;
  logic [EW-1:0]        remb_r, remt_r;
  logic [QW-1:0]        qb_r, qt_r;
  logic                 fb_r, ft_r;
  logic [4:0]           dcnt_r;
  logic signed [CW-1:0] z_r;
  logic [ADDR_W-1:0]    addr_r, clr_cnt_r;
  logic [15:0]          count_r;
  logic                 hit_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [15:0]          out_count_r;
  logic [7:0]           out_code_r;
  logic signed [CW-1:0] out_depth_r;

  // shared multiplier pair
  logic signed [MAW-1:0] ma0, ma1;
  logic signed [MBW-1:0] mb0, mb1;
  logic signed [PRW-1:0] p0_nxt, p1_nxt;
  logic [QW:0]           wb, wc;

  always_comb begin
    wb  = fb_r ? {1'b1, {QW{1'b0}}} : {1'b0, qb_r};
    wc  = ft_r ? {1'b1, {QW{1'b0}}} : {1'b0, qt_r};
    ma0 = MAW'(v2x_r);
    mb0 = MBW'(v1y_r);
    ma1 = MAW'(v2y_r);
    mb1 = MBW'(v1x_r);
    if (cmd.tri_area) begin
      ma0 = MAW'(v0x_r);
      mb0 = MBW'(v1y_r);
      ma1 = MAW'(v0y_r);
      mb1 = MBW'(v1x_r);
    end else if (cmd.t_mul) begin
      ma0 = MAW'(v0x_r);
      mb0 = MBW'(v2y_r);
      ma1 = MAW'(v0y_r);
      mb1 = MBW'(v2x_r);
    end else if (cmd.z_mul) begin
      ma0 = $signed({1'b0, wb});
      mb0 = MBW'(dzb_r);
      ma1 = $signed({1'b0, wc});
      mb1 = MBW'(dzc_r);
    end
    p0_nxt = ma0 * mb0;
    p1_nxt = ma1 * mb1;
  end

  // product difference, sign-corrected for clockwise triangles
  logic signed [PRW-1:0] pdiff, pabs, pdn;
  always_comb begin
    pdiff = p0_r - p1_r;
    pabs  = pdiff[PRW-1] ? -pdiff : pdiff;
    pdn   = neg_r ? -pdiff : pdiff;
  end

  // bounding box clamp
  logic signed [17:0] bsx, bex, bsy, bey, wlim, hlim;
  logic signed [CW:0] mxx_rnd, mxy_rnd;
  always_comb begin
    mxx_rnd = CW'(maxx_r) + (CW+1)'(255);
    mxy_rnd = CW'(maxy_r) + (CW+1)'(255);
    bsx  = 18'(minx_r >>> 8);
    bsy  = 18'(miny_r >>> 8);
    bex  = 18'(mxx_rnd >>> 8);
    bey  = 18'(mxy_rnd >>> 8);
    wlim = $signed({10'd0, cfg.eff_w}) - 18'sd1;
    hlim = $signed({11'd0, cfg.eff_h}) - 18'sd1;
    if (bsx < 0) bsx = '0;
    if (bsy < 0) bsy = '0;
    if (bex > wlim) bex = wlim;
    if (bey > hlim) bey = hlim;
  end

  logic signed [EW-1:0] r_edge;
  assign r_edge = dd_r - s_r - t_r;

  // restoring divider, both weights in parallel
  logic [EW-1:0] rb_sh, rt_sh, remb_nxt, remt_nxt;
  logic          geb, get;
  always_comb begin
    rb_sh    = {remb_r[EW-2:0], 1'b0};
    rt_sh    = {remt_r[EW-2:0], 1'b0};
    geb      = rb_sh >= dd_r;
    get      = rt_sh >= dd_r;
    remb_nxt = geb ? rb_sh - dd_r : rb_sh;
    remt_nxt = get ? rt_sh - dd_r : rt_sh;
  end

  // depth interpolation
  logic signed [PRW:0]    zsum;
  logic signed [PRW-QW:0] zsh;
  logic signed [PRW-QW+1:0] zfull;
  logic signed [CW-1:0]   zsat;
  always_comb begin
    zsum  = (PRW+1)'(p0_r) + (PRW+1)'(p1_r);
    zsh   = zsum[PRW:QW];
    zfull = (PRW-QW+2)'(za_r) + (PRW-QW+2)'(zsh);
    if (zfull < (PRW-QW+2)'(DEPTH_MIN)) zsat = DEPTH_MIN;
    else if (zfull > (PRW-QW+2)'(DEPTH_MAX)) zsat = DEPTH_MAX;
    else zsat = zfull[CW-1:0];
  end

  // store addressing
  logic [8:0]       gw;
  logic [7:0]       gh;
  logic [YW:0]      srow;
  logic [XW:0]      scol;
  logic [YW+9:0]    sprod;
  logic [15:0]      rprod;
  logic [ADDR_W-1:0] samp_idx, rd_idx;
  logic             rd_hit;
  always_comb begin
    gw       = cfg.mode ? {cfg.eff_w, 1'b0} : {1'b0, cfg.eff_w};
    gh       = cfg.mode ? {cfg.eff_h, 1'b0} : {1'b0, cfg.eff_h};
    srow     = cfg.mode ? {y_r, dy_r} : {1'b0, y_r};
    scol     = cfg.mode ? {x_r, dx_r} : {1'b0, x_r};
    sprod    = srow * gw;
    samp_idx = ADDR_W'(sprod + (YW+10)'(scol));
    rprod    = ry_r * gw;
    rd_idx   = ADDR_W'(rprod + 16'(rx_r));
    rd_hit   = ({1'b0, rx_r} < gw) && ({1'b0, ry_r} < gh);
  end

  // store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [RAMW-1:0]   ram_wdata, ram_rdata;
  logic signed [CW-1:0] st_depth;
  logic              pass;

  assign st_depth = ram_rdata[RAMW-1:8];
  assign pass     = z_r > st_depth;

  always_comb begin
    ram_we    = cmd.clr_step || (cmd.dtest && pass);
    ram_waddr = cmd.clr_step ? clr_cnt_r : addr_r;
    ram_wdata = cmd.clr_step ? {DEPTH_MIN, 8'd0}
                             : {z_r, (cfg.mode ? CODE_MODE1 : CODE_MODE0)};
    ram_raddr = cmd.read_issue ? rd_idx : addr_r;
  end

  trz_ram #(.WIDTH(RAMW), .DEPTH(STORE_DEPTH)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic last_sample;
  assign last_sample = (x_r == ex_r) && (y_r == ey_r) &&
                       (dx_r == cfg.mode) && (dy_r == cfg.mode);

  always_comb begin
    st.clr_last    = &clr_cnt_r;
    st.near        = near_r;
    st.degen       = degen_r;
    st.box_empty   = box_empty_r;
    st.in_tri      = !s_r[EW-1] && !t_r[EW-1] && !r_edge[EW-1];
    st.div_last    = (dcnt_r == 5'd31);
    st.last_sample = last_sample;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.load) clr_cnt_r <= '0;
      else if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      ax_r    <= in_vertex_a_x;
      ay_r    <= in_vertex_a_y;
      bx_r    <= in_vertex_b_x;
      by_r    <= in_vertex_b_y;
      cx_r    <= in_vertex_c_x;
      cy_r    <= in_vertex_c_y;
      za_r    <= in_depth_a;
      zb_r    <= in_depth_b;
      zc_r    <= in_depth_c;
      rx_r    <= in_read_x;
      ry_r    <= in_read_y;
      count_r <= '0;
    end
    if (cmd.tri_diff) begin
      v0x_r  <= VW'(bx_r) - VW'(ax_r);
      v0y_r  <= VW'(by_r) - VW'(ay_r);
      v1x_r  <= VW'(cx_r) - VW'(ax_r);
      v1y_r  <= VW'(cy_r) - VW'(ay_r);
      dzb_r  <= VW'(zb_r) - VW'(za_r);
      dzc_r  <= VW'(zc_r) - VW'(za_r);
      near_r <= (za_r > NEAR_LIMIT) && (zb_r > NEAR_LIMIT) && (zc_r > NEAR_LIMIT);
      minx_r <= (ax_r < bx_r) ? ((ax_r < cx_r) ? ax_r : cx_r) : ((bx_r < cx_r) ? bx_r : cx_r);
      maxx_r <= (ax_r > bx_r) ? ((ax_r > cx_r) ? ax_r : cx_r) : ((bx_r > cx_r) ? bx_r : cx_r);
      miny_r <= (ay_r < by_r) ? ((ay_r < cy_r) ? ay_r : cy_r) : ((by_r < cy_r) ? by_r : cy_r);
      maxy_r <= (ay_r > by_r) ? ((ay_r > cy_r) ? ay_r : cy_r) : ((by_r > cy_r) ? by_r : cy_r);
    end
    if (cmd.tri_area || cmd.s_mul || cmd.t_mul || cmd.z_mul) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
    end
    if (cmd.tri_d) begin
      degen_r     <= (pdiff == '0);
      neg_r       <= pdiff[PRW-1];
      dd_r        <= $signed(pabs[EW-1:0]);
      box_empty_r <= (bsx > bex) || (bsy > bey);
      sx_r        <= bsx[XW-1:0];
      ex_r        <= bex[XW-1:0];
      sy_r        <= bsy[YW-1:0];
      ey_r        <= bey[YW-1:0];
    end
    if (cmd.tri_init) begin
      x_r  <= sx_r;
      y_r  <= sy_r;
      dx_r <= 1'b0;
      dy_r <= 1'b0;
    end
    // supersample offsets 0.25 and 0.75 of a cell
    if (cmd.pt) begin
      v2x_r <= $signed({1'b0, x_r, (cfg.mode ? {dx_r, 7'd64} : 8'd0)} ) - PW'(ax_r);
      v2y_r <= $signed({1'b0, y_r, (cfg.mode ? {dy_r, 7'd64} : 8'd0)} ) - PW'(ay_r);
    end
    if (cmd.t_mul) s_r <= $signed(pdn[EW-1:0]);
    if (cmd.edg)   t_r <= $signed(pdn[EW-1:0]);
    if (cmd.div_init) begin
      remb_r <= s_r;
      remt_r <= t_r;
      fb_r   <= s_r >= dd_r;
      ft_r   <= t_r >= dd_r;
      qb_r   <= '0;
      qt_r   <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      remb_r <= remb_nxt;
      remt_r <= remt_nxt;
      qb_r   <= {qb_r[QW-2:0], geb};
      qt_r   <= {qt_r[QW-2:0], get};
      dcnt_r <= dcnt_r + 5'd1;
    end
    if (cmd.z_sum) begin
      z_r    <= zsat;
      addr_r <= samp_idx;
    end
    if (cmd.dtest && pass) count_r <= count_r + 16'd1;
    if (cmd.next) begin
      if (cfg.mode && !dy_r) begin
        dy_r <= 1'b1;
      end else begin
        dy_r <= 1'b0;
        if (cfg.mode && !dx_r) begin
          dx_r <= 1'b1;
        end else begin
          dx_r <= 1'b0;
          if (y_r != ey_r) begin
            y_r <= y_r + 1'b1;
          end else begin
            y_r <= sy_r;
            x_r <= x_r + 1'b1;
          end
        end
      end
    end
    if (cmd.read_issue) hit_r <= rd_hit;
    if (cmd.emit) begin
      out_status_r <= (op_r != OP_TRI) ? STS_DONE :
                      near_r ? STS_NEAR : degen_r ? STS_DEGEN : STS_DONE;
      out_count_r  <= (op_r == OP_TRI) ? count_r : 16'd0;
      out_code_r   <= (op_r == OP_READ && hit_r) ? ram_rdata[7:0] : 8'd0;
      out_depth_r  <= (op_r != OP_READ) ? '0 : (hit_r ? st_depth : DEPTH_MIN);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_samples_written = out_count_r;
  assign out_sample_code     = out_code_r;
  assign out_sample_depth    = out_depth_r;

endmodule

FILE: design/triangle_rasterizer_zbuffer.sv
// Top level: configuration registers, controller and datapath of the triangle rasterizer
// Clear rewrites every store entry, read fetches one entry; a triangle runs setup, then
// visits each sample of the clamped box and divides for the weights of those inside.
// One item at a time; busy stays high until its result strobe, which lasts one cycle.
// Reset: synchronous active-low; afterwards a clearing pass over all 32768 store entries
// runs with busy high, then the block goes idle. Config writes are taken at any time.
module triangle_rasterizer_zbuffer import trz_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_operation,
  input  logic signed [CW-1:0] in_vertex_a_x,
  input  logic signed [CW-1:0] in_vertex_a_y,
  input  logic signed [CW-1:0] in_vertex_b_x,
  input  logic signed [CW-1:0] in_vertex_b_y,
  input  logic signed [CW-1:0] in_vertex_c_x,
  input  logic signed [CW-1:0] in_vertex_c_y,
  input  logic signed [CW-1:0] in_depth_a,
  input  logic signed [CW-1:0] in_depth_b,
  input  logic signed [CW-1:0] in_depth_c,
  input  logic [7:0]           in_read_x,
  input  logic [6:0]           in_read_y,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [15:0]          out_samples_written,
  output logic [7:0]           out_sample_code,
  output logic signed [CW-1:0] out_sample_depth
);

  logic       sample_mode_r;
  logic [7:0] screen_width_r;
  logic [6:0] screen_height_r;
  logic       wr_en;
  cfg_t       cfg;
  cmd_t       cmd;
  stat_t      st;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_mode_r   <= 1'b0;
      screen_width_r  <= MAX_W_CELLS;
      screen_height_r <= MAX_H_CELLS;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SAMPLE_MODE:   sample_mode_r   <= pwdata[0];
        REG_SCREEN_WIDTH:  screen_width_r  <= pwdata[7:0];
        REG_SCREEN_HEIGHT: screen_height_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SAMPLE_MODE:   prdata = {31'd0, sample_mode_r};
      REG_SCREEN_WIDTH:  prdata = {24'd0, screen_width_r};
      REG_SCREEN_HEIGHT: prdata = {25'd0, screen_height_r};
      default:           prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.mode  = sample_mode_r;
    cfg.eff_w = (screen_width_r > MAX_W_CELLS) ? MAX_W_CELLS : screen_width_r;
    cfg.eff_h = (screen_height_r > MAX_H_CELLS) ? MAX_H_CELLS : screen_height_r;
  end

  trz_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .op   (in_operation),
    .st   (st),
    .cmd  (cmd),
    .busy (busy)
  );

  trz_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg),
    .st                 (st),
    .in_operation       (in_operation),
    .in_vertex_a_x      (in_vertex_a_x),
    .in_vertex_a_y      (in_vertex_a_y),
    .in_vertex_b_x      (in_vertex_b_x),
    .in_vertex_b_y      (in_vertex_b_y),
    .in_vertex_c_x      (in_vertex_c_x),
    .in_vertex_c_y      (in_vertex_c_y),
    .in_depth_a         (in_depth_a),
    .in_depth_b         (in_depth_b),
    .in_depth_c         (in_depth_c),
    .in_read_x          (in_read_x),
    .in_read_y          (in_read_y),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_samples_written(out_samples_written),
    .out_sample_code    (out_sample_code),
    .out_sample_depth   (out_sample_depth)
  );

endmodule

FILE: design/trz_checker.sv
// Port-level checker for the triangle rasterizer, bound to the top level
`include "triangle_rasterizer_zbuffer_assert.svh"

module trz_checker import trz_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [15:0] out_samples_written
);

  `TRZ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy not raised after item accept")
  `TRZ_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe held more than one cycle")
  `TRZ_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result shown while busy")
  `TRZ_ASSERT_IMP(a_fail_no_count, out_valid && out_status != STS_DONE, out_samples_written == 16'd0, "samples counted on dropped triangle")

endmodule

bind triangle_rasterizer_zbuffer trz_checker u_trz_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_status         (out_status),
  .out_samples_written(out_samples_written)
);

FILE: test/triangle_rasterizer_zbuffer_test.sv
// Self-checking testbench for the triangle rasterizer with depth store
`timescale 1ns / 100ps

module triangle_rasterizer_zbuffer_test;
  import trz_pkg::*;

  typedef struct packed {
    logic [1:0]           op;
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
    logic signed [CW-1:0] za, zb, zc;
    logic [7:0]           rx;
    logic [6:0]           ry;
  } raster_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [15:0]          written;
    logic [7:0]           code;
    logic signed [CW-1:0] depth;
  } raster_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic out_valid;
  logic [1:0] out_status;
  logic [15:0] out_samples_written;
  logic [7:0] out_sample_code;
  logic signed [CW-1:0] out_sample_depth;

  raster_item_t cur_item = '0;
  raster_item_t pending_items[$];
  raster_result_t expected_results[$];
  int gap_left = 0;
  int errors = 0;

  // shadow of configuration and stores
  logic       mode_q = 1'b0;
  logic [7:0] width_q = 8'd128;
  logic [6:0] height_q = 7'd64;
  logic signed [CW-1:0] depth_mem [STORE_DEPTH];
  logic [7:0]           cov_mem [STORE_DEPTH];

  triangle_rasterizer_zbuffer dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy,
    .in_operation(cur_item.op),
    .in_vertex_a_x(cur_item.ax), .in_vertex_a_y(cur_item.ay),
    .in_vertex_b_x(cur_item.bx), .in_vertex_b_y(cur_item.by),
    .in_vertex_c_x(cur_item.cx), .in_vertex_c_y(cur_item.cy),
    .in_depth_a(cur_item.za), .in_depth_b(cur_item.zb), .in_depth_c(cur_item.zc),
    .in_read_x(cur_item.rx), .in_read_y(cur_item.ry),
    .out_valid, .out_status, .out_samples_written, .out_sample_code, .out_sample_depth
  );

  always #10 clk = ~clk;

  function automatic int eff_w();
    return (width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);
  endfunction

  function automatic int eff_h();
    return (height_q > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_q);
  endfunction

  function automatic void clear_mem();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      depth_mem[i] = DEPTH_MIN;
      cov_mem[i] = 8'd0;
    end
  endfunction

  // floor(n * 2^32 / d), saturated to 2^32 when n >= d; 0 <= n, d > 0
  function automatic longint bary_weight(longint n, longint d);
    longint unsigned r, dd, q;
    r = n;
    dd = d;
    q = 0;
    if (r >= dd) return 64'd1 << 32;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= dd) begin
        r = r - dd;
        q = q | 64'd1;
      end
    end
    return longint'(q);
  endfunction

  function automatic void draw_triangle(input raster_item_t it, output logic [1:0] sts,
                                        output logic [15:0] cnt);
    longint ax, ay, bx, by, cx, cy, za, zb, zc, v0x, v0y, v1x, v1y, d, mn, mx;
    longint sx, ex, sy, ey, px, py, s, t, r, dd, wb, wc, z, idx, near;
    int k, w, h;
    int unsigned count;
    ax = it.ax; ay = it.ay; bx = it.bx; by = it.by; cx = it.cx; cy = it.cy;
    za = it.za; zb = it.zb; zc = it.zc;
    near = NEAR_LIMIT;
    w = eff_w();
    h = eff_h();
    k = mode_q ? 2 : 1;
    count = 0;
    cnt = '0;
    mn = (za < zb) ? za : zb;
    if (zc < mn) mn = zc;
    if (mn > near) begin
      sts = STS_NEAR;
      return;
    end
    v0x = bx - ax; v0y = by - ay; v1x = cx - ax; v1y = cy - ay;
    d = v0x * v1y - v0y * v1x;
    if (d == 0) begin
      sts = STS_DEGEN;
      return;
    end
    sts = STS_DONE;
    mn = (ax < bx) ? ax : bx; if (cx < mn) mn = cx;
    mx = (ax > bx) ? ax : bx; if (cx > mx) mx = cx;
    sx = mn >>> 8; if (sx < 0) sx = 0;
    ex = -((-mx) >>> 8); if (ex > w - 1) ex = w - 1;
    mn = (ay < by) ? ay : by; if (cy < mn) mn = cy;
    mx = (ay > by) ? ay : by; if (cy > mx) mx = cy;
    sy = mn >>> 8; if (sy < 0) sy = 0;
    ey = -((-mx) >>> 8); if (ey > h - 1) ey = h - 1;
    for (longint x = sx; x <= ex; x++)
      for (longint y = sy; y <= ey; y++)
        for (int dx = 0; dx < k; dx++)
          for (int dy = 0; dy < k; dy++) begin
            px = x * 256;
            py = y * 256;
            if (k == 2) begin
              px += 64 + 128 * dx;
              py += 64 + 128 * dy;
            end
            s = (px - ax) * v1y - (py - ay) * v1x;
            t = v0x * (py - ay) - v0y * (px - ax);
            dd = d;
            if (dd < 0) begin
              dd = -dd; s = -s; t = -t;
            end
            r = dd - s - t;
            if (s < 0 || t < 0 || r < 0) continue;
            wb = bary_weight(s, dd);
            wc = bary_weight(t, dd);
            z = za + ((wb * (zb - za) + wc * (zc - za)) >>> 32);
            if (z < longint'(DEPTH_MIN)) z = DEPTH_MIN;
            if (z > longint'(DEPTH_MAX)) z = DEPTH_MAX;
            idx = (y * k + dy) * (longint'(w) * k) + x * k + dx;
            if (idx < 0 || idx >= STORE_DEPTH) continue;
            if (z > longint'(depth_mem[idx])) begin
              depth_mem[idx] = CW'(z);
              cov_mem[idx] = (k == 2) ? CODE_MODE1 : CODE_MODE0;
              count++;
            end
          end
    cnt = count[15:0];
  endfunction

  function automatic raster_result_t predict_result(raster_item_t it);
    raster_result_t res;
    longint gw, gh, idx;
    int k;
    res = '0;
    res.depth = '0;
    case (it.op)
      OP_CLEAR: clear_mem();
      OP_TRI: draw_triangle(it, res.status, res.written);
      OP_READ: begin
        k = mode_q ? 2 : 1;
        gw = longint'(eff_w()) * k;
        gh = longint'(eff_h()) * k;
        res.depth = DEPTH_MIN;
        if (it.rx < gw && it.ry < gh) begin
          idx = it.ry * gw + it.rx;
          if (idx < STORE_DEPTH) begin
            res.depth = depth_mem[idx];
            res.code = cov_mem[idx];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    logic accepted;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      accepted = start && !busy;
      if (accepted) expected_results.push_back(predict_result(cur_item));
      if (accepted || !start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item <= pending_items.pop_front();
          start <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    raster_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d written=%0d code=%0d depth=%0d", $time,
                 out_status, out_samples_written, out_sample_code, out_sample_depth);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_status !== exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, out_status);
          errors++;
        end
        if (out_samples_written !== exp_r.written) begin
          $display("%0t: samples_written exp %0d got %0d", $time, exp_r.written,
                   out_samples_written);
          errors++;
        end
        if (out_sample_code !== exp_r.code) begin
          $display("%0t: sample_code exp %0d got %0d", $time, exp_r.code, out_sample_code);
          errors++;
        end
        if (out_sample_depth !== exp_r.depth) begin
          $display("%0t: sample_depth exp %0d got %0d", $time, exp_r.depth, out_sample_depth);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SAMPLE_MODE: mode_q = val[0];
      REG_SCREEN_WIDTH: width_q = val[7:0];
      default: height_q = val[6:0];
    endcase
  endtask

  task automatic set_screen(logic m, logic [7:0] w, logic [6:0] h);
    write_reg(REG_SAMPLE_MODE, 32'(m));
    write_reg(REG_SCREEN_WIDTH, 32'(w));
    write_reg(REG_SCREEN_HEIGHT, 32'(h));
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() > 0 || start || expected_results.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic raster_item_t noise_item(logic [1:0] op);
    raster_item_t it;
    logic [255:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(raster_item_t)-1:0];
    it.op = op;
    return it;
  endfunction

  function automatic raster_item_t tri_item(int ax, int ay, int bx, int by, int cx, int cy,
                                            int za, int zb, int zc);
    raster_item_t it;
    it = noise_item(OP_TRI);
    it.ax = CW'(ax); it.ay = CW'(ay); it.bx = CW'(bx);
    it.by = CW'(by); it.cx = CW'(cx); it.cy = CW'(cy);
    it.za = CW'(za); it.zb = CW'(zb); it.zc = CW'(zc);
    return it;
  endfunction

  function automatic raster_item_t read_item(int x, int y);
    raster_item_t it;
    it = noise_item(OP_READ);
    it.rx = 8'(x);
    it.ry = 7'(y);
    return it;
  endfunction

  function automatic int rand_depth();
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 16777215)) - 8388608;
    return -int'($urandom_range(3277, 2000000));
  endfunction

  // full_noise: full-range coordinates allowed, only on small screens
  function automatic raster_item_t random_item(bit full_noise);
    raster_item_t it;
    int r, w, h, k, bx0, by0, c[6];
    r = $urandom_range(0, 99);
    w = eff_w();
    h = eff_h();
    k = mode_q ? 2 : 1;
    if (r < 2) return noise_item(2'd3);
    if (r < 42) begin
      if ($urandom_range(0, 4) == 0 || w == 0 || h == 0)
        return read_item($urandom_range(0, 255), $urandom_range(0, 127));
      return read_item($urandom_range(0, (w < 16 ? w : 16) * k - 1),
                       $urandom_range(0, (h < 8 ? h : 8) * k - 1));
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      it = noise_item(OP_TRI);
      it.za = CW'(int'($urandom_range(0, 8388607 + 3276)) - 3276);
      it.zb = CW'(int'($urandom_range(0, 8388607 + 3276)) - 3276);
      it.zc = CW'(int'($urandom_range(0, 8388607 + 3276)) - 3276);
      return it;
    end
    if (full_noise && r < 40) return noise_item(OP_TRI);
    bx0 = $urandom_range(0, w < 16 ? w : 16) - 1;
    by0 = $urandom_range(0, h < 8 ? h : 8) - 1;
    for (int i = 0; i < 6; i += 2) begin
      c[i] = bx0 * 256 + int'($urandom_range(0, 1024)) - 512;
      c[i + 1] = by0 * 256 + int'($urandom_range(0, 1024)) - 512;
    end
    if (r < 46) begin
      c[4] = 2 * c[2] - c[0];
      c[5] = 2 * c[3] - c[1];
    end
    return tri_item(c[0], c[1], c[2], c[3], c[4], c[5],
                    rand_depth(), rand_depth(), rand_depth());
  endfunction

  task automatic random_phase(int n, bit full_noise);
    for (int i = 0; i < n; i++) pending_items.push_back(random_item(full_noise));
    drain();
  endtask

  initial begin
    clear_mem();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, default screen, one sample per cell
    pending_items.push_back(tri_item(256, 256, 1280, 256, 256, 1024, -65536, -65536, -65536));
    pending_items.push_back(read_item(2, 2));
    pending_items.push_back(read_item(1, 1));
    pending_items.push_back(tri_item(256, 256, 256, 1024, 1280, 256,
                                     -131072, -131072, -131072));
    pending_items.push_back(tri_item(256, 256, 256, 1024, 1280, 256,
                                     -32768, -32768, -32768));
    pending_items.push_back(read_item(2, 2));
    pending_items.push_back(tri_item(2560, 2560, 3584, 2560, 2560, 3328,
                                     -8388608, 8388607, 0));
    pending_items.push_back(tri_item(5120, 1280, 5888, 1280, 5120, 2048,
                                     -8388608, -8388608, -8388608));
    pending_items.push_back(tri_item(-8388608, 8388607, 8388607, -8388608, 0, 0,
                                     8388607, 8388607, -3276));
    pending_items.push_back(tri_item(768, 768, 768, 768, 768, 768, -70000, -70000, -70000));
    pending_items.push_back(tri_item(0, 0, 512, 512, 1024, 1024, -70000, -70000, -70000));
    pending_items.push_back(tri_item(-256000, 0, -255000, 0, -256000, 900,
                                     -70000, -70000, -70000));
    pending_items.push_back(tri_item(-512, -512, 768, -512, -512, 768, -50000, -60000, -70000));
    pending_items.push_back(read_item(0, 0));
    pending_items.push_back(read_item(255, 127));
    pending_items.push_back(read_item(127, 63));
    pending_items.push_back(read_item(200, 10));
    pending_items.push_back(noise_item(2'd3));
    pending_items.push_back(noise_item(OP_CLEAR));
    pending_items.push_back(read_item(2, 2));
    drain();

    set_screen(1'b1, 8'd128, 7'd64);
    random_phase(200, 1'b0);
    set_screen(1'b0, 8'd5, 7'd3);
    random_phase(150, 1'b1);
    set_screen(1'b1, 8'd1, 7'd1);
    random_phase(100, 1'b1);
    set_screen(1'b0, 8'd255, 7'd127);
    pending_items.push_back(noise_item(OP_CLEAR));
    random_phase(150, 1'b0);
    set_screen(1'b1, 8'd0, 7'd10);
    random_phase(50, 1'b1);
    set_screen(1'b1, 8'd40, 7'd0);
    random_phase(30, 1'b1);
    set_screen(1'b1, 8'd40, 7'd20);
    pending_items.push_back(noise_item(OP_CLEAR));
    random_phase(200, 1'b0);

    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("triangle_rasterizer_zbuffer regression: pass");
    else
      $display("triangle_rasterizer_zbuffer regression: fail");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("triangle_rasterizer_zbuffer regression: fail");
    $finish;
  end

endmodule

FILE: triangle_rasterizer_zbuffer.f
+incdir+design
design/trz_pkg.sv
design/trz_ram.sv
design/trz_ctrl.sv
design/trz_dp.sv
design/triangle_rasterizer_zbuffer.sv
design/trz_checker.sv
test/triangle_rasterizer_zbuffer_test.sv
